### sv/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg: shared definitions for the trigram count and score unit
// Widths, table contents, index functions and the command and status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcs_pkg;

    // Alphabet and counter geometry.
    localparam int ALPHABET     = 27;
    localparam int COUNT_LEVELS = 256;
    localparam int LETTER_W     = 5;
    localparam int SCORE_W      = 5;
    localparam int CNT_W        = $clog2(COUNT_LEVELS);
    localparam int DIG_DEPTH    = ALPHABET * ALPHABET;
    localparam int TRI_DEPTH    = ALPHABET * ALPHABET * ALPHABET;
    localparam int DIG_AW       = $clog2(DIG_DEPTH);
    localparam int TRI_AW       = $clog2(TRI_DEPTH);

    // Per-word random draw.
    localparam int DRAW_W    = 15;
    localparam int SEED_STEP = 625;

    // Log table values span -LOG_BIAS .. 12; scores span 0 .. SCORE_MAX.
    localparam int LOG_W     = 5;
    localparam int LOG_BIAS  = 10;
    localparam int SURP_W    = 7;
    localparam int SCORE_MAX = 22;
    localparam int LOG_STEPS = 12;
    localparam int LOG_BRK [LOG_STEPS] =
        '{2, 5, 11, 23, 43, 68, 96, 126, 156, 187, 217, 248};

    // Bump thresholds, ceil(32768 * exp(-n/30.497)), at most 2^DRAW_W.
    localparam int THR_W = DRAW_W + 1;
    localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

    typedef logic [LETTER_W-1:0]     letter_t;
    typedef logic [SCORE_W-1:0]      score_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [DRAW_W-1:0]       draw_t;
    typedef logic signed [LOG_W-1:0] log_t;
    typedef logic [DIG_AW-1:0]       dig_addr_t;
    typedef logic [TRI_AW-1:0]       tri_addr_t;
    typedef logic [THR_W-1:0]        thr_rom_t [COUNT_LEVELS];

    // Controller to datapath.
    typedef struct packed {
        logic accept;     // take the offered letter
        logic clr_step;   // clear one counter location
        logic slot;       // 0: trigram (a,b,x), 1: closing trigram (b,x,pad)
        logic rd_first;   // first memory read of a slot
        logic modify;     // write back bumps, or latch first logs when scoring
        logic eval;       // fold one trigram surprise into the running max
        logic emit;       // load the score into the output register
    } tcs_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic run0;       // offered letter needs the first slot
        logic run1;       // offered letter needs the closing slot
        logic score_item; // item in flight is a scoring item
        logic clr_last;   // clearing pass is at its final location
        logic out_free;   // output register can take a new score
    } tcs_sts_t;

    // floor(a*b / 2^62), kept to 64 bits.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Evaluated once at elaboration: exp(-1/30.497) by a 20-term series in
    // Q62, then successive powers rounded up to integer thresholds.
    function automatic thr_rom_t build_thr_rom();
        thr_rom_t    rom;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] up;
        quo  = ONE_Q62 / 64'd30497;
        rem  = ONE_Q62 % 64'd30497;
        x    = quo * 64'd1000 + (rem * 64'd1000) / 64'd30497;
        term = ONE_Q62;
        r    = ONE_Q62;
        p    = ONE_Q62;
        term = mul_q62(term, x) / 64'd1;  r = r - term;
        term = mul_q62(term, x) / 64'd2;  r = r + term;
        term = mul_q62(term, x) / 64'd3;  r = r - term;
        term = mul_q62(term, x) / 64'd4;  r = r + term;
        term = mul_q62(term, x) / 64'd5;  r = r - term;
        term = mul_q62(term, x) / 64'd6;  r = r + term;
        term = mul_q62(term, x) / 64'd7;  r = r - term;
        term = mul_q62(term, x) / 64'd8;  r = r + term;
        term = mul_q62(term, x) / 64'd9;  r = r - term;
        term = mul_q62(term, x) / 64'd10; r = r + term;
        term = mul_q62(term, x) / 64'd11; r = r - term;
        term = mul_q62(term, x) / 64'd12; r = r + term;
        term = mul_q62(term, x) / 64'd13; r = r - term;
        term = mul_q62(term, x) / 64'd14; r = r + term;
        term = mul_q62(term, x) / 64'd15; r = r - term;
        term = mul_q62(term, x) / 64'd16; r = r + term;
        term = mul_q62(term, x) / 64'd17; r = r - term;
        term = mul_q62(term, x) / 64'd18; r = r + term;
        term = mul_q62(term, x) / 64'd19; r = r - term;
        term = mul_q62(term, x) / 64'd20; r = r + term;
        for (int n = 0; n < COUNT_LEVELS; n++) begin
            up     = p + ((64'd1 << 47) - 64'd1);
            rom[n] = THR_W'(up >> 47);
            p      = mul_q62(p, r);
        end
        return rom;
    endfunction

    localparam thr_rom_t THR_ROM = build_thr_rom();

    // Integer log of a counter value.
    function automatic log_t log_rom(input cnt_t n);
        log_t v;
        v = -LOG_W'(LOG_BIAS);
        for (int i = 0; i < LOG_STEPS; i++) begin
            if (int'(n) >= LOG_BRK[i]) begin
                v = LOG_W'(i + 1);
            end
        end
        return v;
    endfunction

    // Approximate-counting increment against this word's draw.
    function automatic cnt_t bump_count(input cnt_t n, input draw_t draw);
        cnt_t v;
        v = n;
        if (int'(n) < COUNT_LEVELS - 1 && THR_ROM[n] > {1'b0, draw}) begin
            v = n + 1'b1;
        end
        return v;
    endfunction

    function automatic dig_addr_t di_index(input letter_t a, input letter_t b);
        return DIG_AW'(a) * DIG_AW'(ALPHABET) + DIG_AW'(b);
    endfunction

    function automatic tri_addr_t tri_index(input letter_t a, input letter_t b,
                                            input letter_t c);
        return TRI_AW'(di_index(a, b)) * TRI_AW'(ALPHABET) + TRI_AW'(c);
    endfunction

endpackage

### sv/tcs_in_if.sv
// ----------------------------------------------------------------------------
// tcs_in_if: letter channel
// Valid/ready channel carrying one letter, its action and the word-end mark.
// ----------------------------------------------------------------------------
interface tcs_in_if;
    logic              valid;
    logic              ready;
    logic              action;
    tcs_pkg::letter_t  letter;
    logic              last;

    modport source (output valid, output action, output letter, output last,
                    input ready);
    modport sink   (input valid, input action, input letter, input last,
                    output ready);
endinterface

### sv/tcs_out_if.sv
// ----------------------------------------------------------------------------
// tcs_out_if: score channel
// Valid/ready channel carrying one word score.
// ----------------------------------------------------------------------------
interface tcs_out_if;
    logic             valid;
    logic             ready;
    tcs_pkg::score_t  score;

    modport source (output valid, output score, input ready);
    modport sink   (input valid, input score, output ready);
endinterface

### sv/trigram_count_and_score_unit.sv
// ----------------------------------------------------------------------------
// trigram_count_and_score_unit: letter-serial trigram statistics and scoring
// Counts digrams and trigrams of padded words with approximate 8-bit
// counters, or scores each word by its most surprising trigram.
//
//   channel    role  payload                  transfer
//   letter_ch  in    action, letter, last     one letter of a word
//   score_ch   out   score                    one score per scored word end
//
// A counting letter runs slot 0, and also the closing slot at a word end; a
// scoring letter adds an evaluate step to each slot and an emit step at a word
// end, and skips slot 0 when it opens a word. The steps follow from the counter
// memories, which take one read and one write a cycle: each trigram slot is a
// serial read followed by a write-back or a second digram read.
// After reset a clearing pass zeroes both counter memories, one location per
// cycle over all 19683 trigram locations, with letter_ch.ready low.
// A score waits in the output register while letters keep being taken; a
// second score waits in the controller until the first transfer completes.
// ----------------------------------------------------------------------------
module trigram_count_and_score_unit (
    input  logic  clk,
    input  logic  rst_n,
    tcs_in_if.sink     letter_ch,
    tcs_out_if.source  score_ch
);
    import tcs_pkg::*;

    tcs_cmd_t cmd;
    tcs_sts_t sts;
    logic     in_ready;

    assign letter_ch.ready = in_ready;

    tcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (letter_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .action    (letter_ch.action),
        .letter    (letter_ch.letter),
        .last      (letter_ch.last),
        .out_valid (score_ch.valid),
        .out_ready (score_ch.ready),
        .score     (score_ch.score)
    );

endmodule

### sv/tcs_ctrl.sv
// ----------------------------------------------------------------------------
// tcs_ctrl: sequencing controller
// Runs the clearing pass after reset, then steps each letter through up to
// two trigram slots of read, modify and evaluate, and hands scores out.
// ----------------------------------------------------------------------------
module tcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcs_pkg::tcs_sts_t sts,
    output tcs_pkg::tcs_cmd_t cmd
);
    import tcs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_EVAL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   slot_reg;
    logic   slot_next;
    logic   pend_reg;
    logic   pend_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_ready && in_valid;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.clr_step = (state_reg == ST_CLEAR);
        cmd.slot     = slot_reg;
        cmd.rd_first = (state_reg == ST_READ);
        cmd.modify   = (state_reg == ST_MODIFY);
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.emit     = (state_reg == ST_EMIT) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (sts.run0)
                    begin
                        state_next = ST_READ;
                        slot_next  = 1'b0;
                        pend_next  = sts.run1;
                    end
                    else if (sts.run1)
                    begin
                        state_next = ST_READ;
                        slot_next  = 1'b1;
                        pend_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY, ST_EVAL:
            begin
                priority if (state_reg == ST_MODIFY && sts.score_item)
                begin
                    state_next = ST_EVAL;
                end
                else if (pend_reg)
                begin
                    state_next = ST_READ;
                    slot_next  = 1'b1;
                    pend_next  = 1'b0;
                end
                else if (slot_reg && sts.score_item)
                begin
                    // The closing slot of a scoring word ends in a result.
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            slot_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            pend_reg  <= pend_next;
        end
    end

    // Every read is followed by its write-back or first-log cycle.
    a_read_then_modify: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_first |=> cmd.modify)
        else $error("read cycle not followed by modify");

    // An accepted letter that has work starts a slot in the next cycle.
    a_accept_starts_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && (sts.run0 || sts.run1) |=> cmd.rd_first)
        else $error("accepted letter did not start a slot");

    // The pending closing slot is always slot 1 after slot 0.
    a_pend_only_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !slot_reg)
        else $error("closing slot pending while already in it");

    // Scores are only produced at the end of a scoring item.
    a_emit_scoring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.score_item && slot_reg)
        else $error("emit outside the closing slot of a scoring item");

endmodule

### sv/tcs_dpath.sv
// ----------------------------------------------------------------------------
// tcs_dpath: counter memories, letter history and scoring datapath
// Holds the digram and trigram counter memories, the word draw, the letter
// history and the running maximum, and the output register.
// ----------------------------------------------------------------------------
module tcs_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  tcs_pkg::tcs_cmd_t cmd,
    output tcs_pkg::tcs_sts_t sts,
    input  logic              action,
    input  tcs_pkg::letter_t  letter,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output tcs_pkg::score_t   score
);
    import tcs_pkg::*;

    cnt_t dig_mem [DIG_DEPTH];
    cnt_t tri_mem [TRI_DEPTH];

    letter_t   prev_reg;
    letter_t   prev2_reg;
    draw_t     seed_reg;
    draw_t     seed_next;
    draw_t     draw_reg;
    score_t    max_reg;
    tri_addr_t clr_idx_reg;
    logic      out_valid_reg;
    score_t    score_reg;

    letter_t   cur_a_reg;
    letter_t   cur_b_reg;
    letter_t   cur_x_reg;
    logic      score_item_reg;
    logic      start_reg;
    log_t      log_d1_reg;
    log_t      log_t_reg;
    cnt_t      dig_rdata_reg;
    cnt_t      tri_rdata_reg;

    letter_t   x_in;
    logic      start_in;
    letter_t   p;
    letter_t   q;
    letter_t   r;
    dig_addr_t dig_raddr;
    tri_addr_t tri_raddr;
    logic      dig_we;
    dig_addr_t dig_waddr;
    cnt_t      dig_wdata;
    logic      tri_we;
    tri_addr_t tri_waddr;
    cnt_t      tri_wdata;
    logic      clr_dig;
    logic      bump_phase;

    logic signed [SURP_W-1:0] pair_sum;
    logic signed [SURP_W-1:0] half_sum;
    logic signed [SURP_W-1:0] surprise;
    logic                     new_max;

    // Codes outside the alphabet act as the pad and end the letter history.
    assign x_in      = (int'(letter) >= ALPHABET) ? '0 : letter;
    assign start_in  = (prev_reg == '0);
    assign seed_next = seed_reg + DRAW_W'(SEED_STEP);

    assign sts.run0       = !action || !start_in;
    assign sts.run1       = last;
    assign sts.score_item = score_item_reg;
    assign sts.clr_last   = (clr_idx_reg == TRI_AW'(TRI_DEPTH - 1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    // Slot 0 works on (a,b,x), slot 1 on (b,x,pad).
    assign p = cmd.slot ? cur_b_reg : cur_a_reg;
    assign q = cmd.slot ? cur_x_reg : cur_b_reg;
    assign r = cmd.slot ? '0        : cur_x_reg;

    // Scoring reads digram (p,q) first and (q,r) second; counting bumps (q,r).
    assign dig_raddr = (cmd.rd_first && score_item_reg) ? di_index(p, q) : di_index(q, r);
    assign tri_raddr = tri_index(p, q, r);

    assign bump_phase = cmd.modify && !score_item_reg;
    assign clr_dig    = (int'(clr_idx_reg) < DIG_DEPTH);

    always_comb
    begin
        dig_we    = (cmd.clr_step && clr_dig) || bump_phase;
        dig_waddr = cmd.clr_step ? clr_idx_reg[DIG_AW-1:0] : dig_raddr;
        dig_wdata = cmd.clr_step ? '0 : bump_count(dig_rdata_reg, draw_reg);
        // The opening trigram of a word does not exist, so slot 0 skips it there.
        tri_we    = cmd.clr_step || (bump_phase && (cmd.slot || !start_reg));
        tri_waddr = cmd.clr_step ? clr_idx_reg : tri_raddr;
        tri_wdata = cmd.clr_step ? '0 : bump_count(tri_rdata_reg, draw_reg);
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            dig_mem[dig_waddr] <= dig_wdata;
        end
        dig_rdata_reg <= dig_mem[dig_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tri_we)
        begin
            tri_mem[tri_waddr] <= tri_wdata;
        end
        tri_rdata_reg <= tri_mem[tri_raddr];
    end

    // floor((L1 + L2) / 2) - L(tri), kept positive before the halving.
    always_comb
    begin
        pair_sum = SURP_W'(log_d1_reg) + SURP_W'(log_rom(dig_rdata_reg))
                 + SURP_W'(2 * LOG_BIAS);
        half_sum = pair_sum >>> 1;
        surprise = half_sum - SURP_W'(LOG_BIAS) - SURP_W'(log_t_reg);
        new_max  = surprise > $signed({{(SURP_W - SCORE_W){1'b0}}, max_reg});
    end

    // Item payload and first-read logs.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_a_reg      <= prev2_reg;
            cur_b_reg      <= prev_reg;
            cur_x_reg      <= x_in;
            score_item_reg <= action;
            start_reg      <= start_in;
        end
        if (cmd.modify)
        begin
            log_d1_reg <= log_rom(dig_rdata_reg);
            log_t_reg  <= log_rom(tri_rdata_reg);
        end
        if (cmd.emit)
        begin
            score_reg <= max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            prev2_reg     <= '0;
            seed_reg      <= '0;
            draw_reg      <= '0;
            max_reg       <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step && !sts.clr_last)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                if (last)
                begin
                    prev_reg  <= '0;
                    prev2_reg <= '0;
                end
                else
                begin
                    prev2_reg <= prev_reg;
                    prev_reg  <= x_in;
                end
                if (start_in)
                begin
                    max_reg <= '0;
                end
                if (!action && start_in)
                begin
                    seed_reg <= seed_next;
                    draw_reg <= seed_next;
                end
            end
            else if (cmd.eval && new_max)
            begin
                max_reg <= surprise[SCORE_W-1:0];
            end
            priority if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;

    // The running maximum never leaves the score range.
    a_max_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(max_reg) <= SCORE_MAX)
        else $error("running maximum out of range");

    // Counters are only bumped once the clearing pass is finished.
    a_no_bump_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !bump_phase && !cmd.accept)
        else $error("counter update during clearing pass");

    // A waiting score holds steady until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(score_reg))
        else $error("score changed while waiting for transfer");

endmodule

### verif/trigram_count_and_score_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trigram_count_and_score_unit_checker: score predictor and comparator
// Watches both channels of the unit. Every letter transfer updates a private
// copy of the digram and trigram statistics, the per-word draw and the letter
// history. A scored word end queues its expected score, and every score
// transfer is compared with the oldest entry in that queue.
// ----------------------------------------------------------------------------
package tcs_tb_pkg;

    typedef enum logic {
        ACT_COUNT = 1'b0,
        ACT_SCORE = 1'b1
    } letter_action_e;

    // Letter code that pads each word on both sides.
    localparam int PAD_CODE = 0;

endpackage

module trigram_count_and_score_unit_checker (
    input  logic clk,
    input  logic rst_n,
    tcs_in_if    letter_ch,
    tcs_out_if   score_ch,
    output int   mismatches,
    output int   open_scores
);
    import tcs_pkg::*;
    import tcs_tb_pkg::*;

    localparam int REPORT_LIMIT   = 10;
    localparam int LOG_FLOOR      = -10;
    localparam int LOG_EDGE_COUNT = 12;
    localparam int LOG_EDGES [LOG_EDGE_COUNT] =
        '{2, 5, 11, 23, 43, 68, 96, 126, 156, 187, 217, 248};

    int unsigned  bump_limit [COUNT_LEVELS];
    byte unsigned pair_cnt   [DIG_DEPTH];
    byte unsigned triple_cnt [TRI_DEPTH];
    draw_t        seed_reg;
    draw_t        word_draw;
    int           prev_code;
    int           prev2_code;
    int           word_max;
    score_t       expected_scores [$];

    // Product of two Q62 values, kept in Q62.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return wide[125:62];
    endfunction

    // Bump thresholds: exp(-1/30.497) by series, then rounded-up powers.
    initial
    begin
        logic [63:0] one_q;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] pw;
        mismatches  = 0;
        open_scores = 0;
        one_q = 64'd1 << 62;
        quo   = one_q / 64'd30497;
        rem   = one_q % 64'd30497;
        step  = quo * 64'd1000 + (rem * 64'd1000) / 64'd30497;
        term  = one_q;
        ratio = one_q;
        pw    = one_q;
        for (int k = 1; k <= 20; k++)
        begin
            term = q62_mul(term, step) / 64'(k);
            if (k % 2 == 1)
                ratio = ratio - term;
            else
                ratio = ratio + term;
        end
        for (int n = 0; n < COUNT_LEVELS; n++)
        begin
            bump_limit[n] = int'((pw + ((64'd1 << 47) - 64'd1)) >> 47);
            pw = q62_mul(pw, ratio);
        end
    end

    function automatic int pair_at(input int a, input int b);
        return a * ALPHABET + b;
    endfunction

    function automatic int triple_at(input int a, input int b, input int c);
        return (a * ALPHABET + b) * ALPHABET + c;
    endfunction

    function automatic int count_log(input int n);
        int v;
        v = LOG_FLOOR;
        for (int i = 0; i < LOG_EDGE_COUNT; i++)
        begin
            if (n >= LOG_EDGES[i])
                v = i + 1;
        end
        return v;
    endfunction

    // Approximate counting: a counter moves up only while its threshold
    // exceeds the draw of the current word, and never past the top level.
    function automatic int approx_incr(input int n);
        if (n < COUNT_LEVELS - 1 && bump_limit[n] > word_draw)
            return n + 1;
        return n;
    endfunction

    function automatic void fold_surprise(input int a, input int b, input int c);
        int pair_sum;
        int surprise;
        pair_sum = count_log(pair_cnt[pair_at(a, b)]) + count_log(pair_cnt[pair_at(b, c)]);
        surprise = (pair_sum - 2 * LOG_FLOOR) / 2 + LOG_FLOOR
                   - count_log(triple_cnt[triple_at(a, b, c)]);
        if (surprise > word_max)
            word_max = surprise;
    endfunction

    function automatic void absorb_letter(input logic act, input int code, input bit fin,
                                          output bit scored, output score_t result);
        int a;
        int b;
        int x;
        bit start;
        x = (code >= ALPHABET) ? PAD_CODE : code;
        a = prev2_code;
        b = prev_code;
        start  = (b == PAD_CODE);
        scored = 1'b0;
        result = '0;
        if (start)
            word_max = 0;
        if (act == ACT_COUNT)
        begin
            if (start)
            begin
                seed_reg  = seed_reg + draw_t'(SEED_STEP);
                word_draw = seed_reg;
            end
            pair_cnt[pair_at(b, x)] = 8'(approx_incr(pair_cnt[pair_at(b, x)]));
            if (!start)
                triple_cnt[triple_at(a, b, x)] =
                    8'(approx_incr(triple_cnt[triple_at(a, b, x)]));
            if (fin)
            begin
                triple_cnt[triple_at(b, x, PAD_CODE)] =
                    8'(approx_incr(triple_cnt[triple_at(b, x, PAD_CODE)]));
                pair_cnt[pair_at(x, PAD_CODE)] =
                    8'(approx_incr(pair_cnt[pair_at(x, PAD_CODE)]));
            end
        end
        else
        begin
            if (!start)
                fold_surprise(a, b, x);
            if (fin)
            begin
                fold_surprise(b, x, PAD_CODE);
                result = score_t'(word_max);
                scored = 1'b1;
            end
        end
        if (fin)
        begin
            prev_code  = PAD_CODE;
            prev2_code = PAD_CODE;
            word_max   = 0;
        end
        else
        begin
            prev2_code = b;
            prev_code  = x;
        end
    endfunction

    function automatic void record_fault(input string detail);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, detail);
    endfunction

    // Score transfers are checked before the letter of the same edge is taken,
    // so a result can never be matched against an expectation it produced.
    always @(posedge clk or negedge rst_n)
    begin
        bit     scored;
        score_t predicted;
        score_t oldest;
        if (!rst_n)
        begin
            foreach (pair_cnt[i])
                pair_cnt[i] = 0;
            foreach (triple_cnt[i])
                triple_cnt[i] = 0;
            seed_reg   = '0;
            word_draw  = '0;
            prev_code  = PAD_CODE;
            prev2_code = PAD_CODE;
            word_max   = 0;
            expected_scores.delete();
        end
        else
        begin
            if (score_ch.valid && score_ch.ready)
            begin
                if (expected_scores.size() == 0)
                    record_fault($sformatf("score %0d arrived with none expected",
                                           score_ch.score));
                else
                begin
                    oldest = expected_scores.pop_front();
                    if (score_ch.score !== oldest)
                        record_fault($sformatf("score mismatch: expected %0d, actual %0d",
                                               oldest, score_ch.score));
                end
            end
            if (letter_ch.valid && letter_ch.ready)
            begin
                absorb_letter(letter_ch.action, int'(letter_ch.letter), letter_ch.last,
                              scored, predicted);
                if (scored)
                    expected_scores.push_back(predicted);
            end
        end
        open_scores = expected_scores.size();
    end

endmodule

### verif/trigram_count_and_score_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trigram_count_and_score_unit_tb: stimulus and verdict for the trigram unit
// Drives one long word to build up high counter values, then sends short
// directed words and about seven hundred random letters, mostly well-formed
// words over a small alphabet so the statistics build up. Both channels stall
// in random bursts.
// ----------------------------------------------------------------------------
module trigram_count_and_score_unit_tb;
    import tcs_pkg::*;
    import tcs_tb_pkg::*;

    localparam int LONG_RUN     = 160;
    localparam int RANDOM_ITEMS = 720;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int TOP_CODE     = (1 << LETTER_W) - 1;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   scores_outstanding;
    int   idle_pct;
    int   letters_sent;

    tcs_in_if  letter_if ();
    tcs_out_if score_if ();

    trigram_count_and_score_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .letter_ch (letter_if),
        .score_ch  (score_if)
    );

    trigram_count_and_score_unit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .letter_ch   (letter_if),
        .score_ch    (score_if),
        .mismatches  (mismatch_count),
        .open_scores (scores_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Score side back-pressure in bursts.
    initial
    begin
        score_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < idle_pct)
            begin
                score_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            score_if.ready <= 1'b1;
        end
    end

    function automatic int pick_pad();
        if ($urandom_range(0, 1) == 0)
            return PAD_CODE;
        return $urandom_range(ALPHABET, TOP_CODE);
    endfunction

    task automatic send_letter(input letter_action_e act, input int code, input bit fin);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            letter_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        letter_if.valid  <= 1'b1;
        letter_if.action <= act;
        letter_if.letter <= letter_t'(code);
        letter_if.last   <= fin;
        @(posedge clk);
        while (!letter_if.ready)
            @(posedge clk);
        letters_sent++;
    endtask

    task automatic send_word(input letter_action_e act, input int len, input int top_code,
                             input int flip_pct, input int pad_pct);
        letter_action_e each;
        int             code;
        for (int i = 0; i < len; i++)
        begin
            each = act;
            if ($urandom_range(0, 99) < flip_pct)
                each = (act == ACT_COUNT) ? ACT_SCORE : ACT_COUNT;
            if ($urandom_range(0, 99) < pad_pct)
                code = pick_pad();
            else
                code = $urandom_range(1, top_code);
            send_letter(each, code, i == len - 1);
        end
    endtask

    initial
    begin
        int random_base;
        int word_no;
        int sel;
        int len;
        int top_code;
        letter_action_e act;
        letters_sent = 0;
        idle_pct     = 4;
        rst_n            <= 1'b0;
        letter_if.valid  <= 1'b0;
        letter_if.action <= ACT_COUNT;
        letter_if.letter <= '0;
        letter_if.last   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // One long word pushes its counters as far as the word's draw allows.
        for (int i = 0; i < LONG_RUN; i++)
            send_letter(ACT_COUNT, ALPHABET - 1, i == LONG_RUN - 1);

        idle_pct = 20;
        send_letter(ACT_SCORE, ALPHABET - 1, 1'b0);
        send_letter(ACT_SCORE, ALPHABET - 1, 1'b0);
        send_letter(ACT_SCORE, ALPHABET - 1, 1'b1);
        send_letter(ACT_COUNT, 1, 1'b0);
        send_letter(ACT_COUNT, ALPHABET - 1, 1'b1);
        send_letter(ACT_SCORE, 1, 1'b0);
        send_letter(ACT_SCORE, ALPHABET - 1, 1'b1);
        send_letter(ACT_COUNT, 1, 1'b1);
        send_letter(ACT_SCORE, 1, 1'b1);
        // Out-of-range codes break the letter history in the middle of a word.
        send_letter(ACT_COUNT, 3, 1'b0);
        send_letter(ACT_COUNT, TOP_CODE, 1'b0);
        send_letter(ACT_COUNT, 4, 1'b1);
        send_letter(ACT_SCORE, 3, 1'b0);
        send_letter(ACT_SCORE, ALPHABET, 1'b0);
        send_letter(ACT_SCORE, 4, 1'b1);
        send_letter(ACT_SCORE, PAD_CODE, 1'b1);
        send_letter(ACT_COUNT, 1, 1'b0);
        send_letter(ACT_SCORE, ALPHABET - 1, 1'b0);
        send_letter(ACT_COUNT, 2, 1'b1);
        send_letter(ACT_SCORE, 5, 1'b0);
        send_letter(ACT_COUNT, 5, 1'b1);
        send_letter(ACT_SCORE, 2, 1'b0);
        send_letter(ACT_SCORE, 1, 1'b1);

        random_base = letters_sent;
        word_no     = 0;
        while (letters_sent - random_base < RANDOM_ITEMS)
        begin
            if (letters_sent - random_base >= RANDOM_ITEMS - QUIET_TAIL)
                idle_pct = 0;
            else if (word_no % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            if ($urandom_range(0, 99) < 6)
                send_letter(letter_action_e'($urandom_range(0, 1)), pick_pad(),
                            1'($urandom_range(0, 1)));
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    len = $urandom_range(1, 4);
                else if (sel < 95)
                    len = $urandom_range(5, 10);
                else
                    len = $urandom_range(11, 20);
                // A narrow alphabet lets the counters climb far enough for
                // positive scores.
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    top_code = 4;
                else if (sel < 9)
                    top_code = ALPHABET - 1;
                else
                    top_code = 8;
                act = ($urandom_range(0, 99) < 55) ? ACT_COUNT : ACT_SCORE;
                send_word(act, len, top_code, ($urandom_range(0, 9) == 0) ? 30 : 0,
                          ($urandom_range(0, 9) == 0) ? 20 : 0);
            end
            word_no++;
        end
        letter_if.valid <= 1'b0;

        while (scores_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && scores_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
